// ----- src/sks_pkg.sv -----
// sks_pkg: types, constants and codes shared by the sorted key set.
// No dependencies.
`timescale 1ns / 1ps

package sks_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_BITS = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned KEY_FIELD_W = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ENTRY_W     = 5;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 8;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } slot_t;

  typedef struct packed {
    logic ins;
    logic del;
    key_t key;
  } cell_ctrl_t;

endpackage

// ----- src/sks_cell.sv -----
// sks_cell: one slot of the sorted chain; compares its key with the request
// key and takes its own, the request's or a neighbour's slot. Uses sks_pkg.
`timescale 1ns / 1ps

module sks_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sks_pkg::cell_ctrl_t ctrl_i,
  input  sks_pkg::slot_t      prev_slot_i,
  input  logic                prev_lt_i,
  input  sks_pkg::slot_t      next_slot_i,
  output sks_pkg::slot_t      slot_o,
  output logic                lt_o,
  output logic                eq_o
);
  import sks_pkg::*;

  logic valid_q, valid_d;
  key_t key_q, key_d;

  assign lt_o   = valid_q && (key_q < ctrl_i.key);
  assign eq_o   = valid_q && (key_q == ctrl_i.key);
  assign slot_o = '{valid: valid_q, key: key_q};

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (ctrl_i.ins && !lt_o) begin
      if (prev_lt_i) begin
        valid_d = 1'b1;
        key_d   = ctrl_i.key;
      end else begin
        valid_d = prev_slot_i.valid;
        key_d   = prev_slot_i.key;
      end
    end else if (ctrl_i.del && !lt_o) begin
      valid_d = next_slot_i.valid;
      key_d   = next_slot_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ----- src/sorted_key_set_top.sv -----
// sorted_key_set_top: stream wrapper, chain of sks_cell slots, entry counter
// and result register. Uses sks_pkg and sks_cell.
`timescale 1ns / 1ps

// Holds up to CAPACITY distinct keys in ascending order in a row of cells.
// One request (insert or delete) is taken per cycle: every cell compares its
// key with the request key in the same cycle and either keeps its slot,
// takes the new key, or shifts from its neighbour, so a request completes in
// the cycle it is accepted and its result appears in the output register on
// the next cycle. The output register lets a new request in while the
// previous result is being taken; input ready drops only while a result is
// held and not taken. No clearing pass after reset: slots start empty.
module sorted_key_set_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [sks_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // key[15:0]
  input  logic                            s_axis_tuser_i,  // kind[0]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [sks_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o   // status[1:0], entry_count[6:2], pad
);
  import sks_pkg::*;

  logic       accept;
  kind_e      kind;
  key_t       req_key;
  cell_ctrl_t ctrl;
  slot_t      slots   [CAPACITY];
  logic [CAPACITY-1:0] lt, eq;
  logic       present, full;
  logic [CNT_W-1:0] count_q, count_d;
  status_e    status;
  logic       out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign kind            = kind_e'(s_axis_tuser_i);
  assign req_key         = s_axis_tdata_i[KEY_BITS-1:0];

  assign present = |eq;
  assign full    = slots[CAPACITY-1].valid;

  always_comb begin
    ctrl.key = req_key;
    ctrl.ins = 1'b0;
    ctrl.del = 1'b0;
    status   = ST_NOCHANGE;
    count_d  = count_q;
    if (kind == KIND_INSERT) begin
      if (present) begin
        status = ST_NOCHANGE;
      end else if (full) begin
        status = ST_FULL;
      end else begin
        status   = ST_DONE;
        ctrl.ins = accept;
        count_d  = count_q + 1'b1;
      end
    end else begin
      if (present) begin
        status   = ST_DONE;
        ctrl.del = accept;
        count_d  = count_q - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t prev_slot, next_slot;
    logic  prev_lt;
    if (i == 0) begin : g_first
      assign prev_slot = '{valid: 1'b0, key: '0};
      assign prev_lt   = 1'b1;
    end else begin : g_mid
      assign prev_slot = slots[i-1];
      assign prev_lt   = lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_slot = '{valid: 1'b0, key: '0};
    end else begin : g_inner
      assign next_slot = slots[i+1];
    end
    sks_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_slot_i (prev_slot),
      .prev_lt_i   (prev_lt),
      .next_slot_i (next_slot),
      .slot_o      (slots[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {1'b0, ENTRY_W'(count_d), status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ----- bench/sks_checker.sv -----
// sks_checker: watches both stream channels of sorted_key_set_top, keeps its own
// ordered copy of the key set to predict every result, and counts mismatches.
// Depends on sks_pkg.
`timescale 1ns / 1ps

module sks_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [sks_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                           s_axis_tuser_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [sks_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);
  import sks_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] entries;
  } set_result_t;

  key_t        held_keys_q[$];
  set_result_t due_results_q[$];
  int unsigned bad_results = 0;
  int unsigned results_seen = 0;

  // Applies one request to the held keys and returns the result it should give.
  function automatic set_result_t apply_request(kind_e kind, key_t key);
    set_result_t res;
    int unsigned place;
    bit          found;
    bit          present;
    place = held_keys_q.size();
    found = 1'b0;
    for (int i = 0; i < held_keys_q.size(); i++) begin
      if (!found && held_keys_q[i] >= key) begin
        place = i;
        found = 1'b1;
      end
    end
    present = found && held_keys_q[place] == key;
    if (kind == KIND_INSERT) begin
      if (present) begin
        res.status = ST_NOCHANGE;
      end else if (held_keys_q.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        held_keys_q.insert(place, key);
        res.status = ST_DONE;
      end
    end else begin
      if (!present) begin
        res.status = ST_NOCHANGE;
      end else begin
        held_keys_q.delete(place);
        res.status = ST_DONE;
      end
    end
    res.entries = ENTRY_W'(held_keys_q.size());
    return res;
  endfunction

  task automatic check_result(logic [OUT_DATA_W-1:0] word);
    set_result_t want;
    logic [STATUS_W-1:0] got_status;
    logic [ENTRY_W-1:0]  got_entries;
    got_status  = word[STATUS_W-1:0];
    got_entries = word[STATUS_W+ENTRY_W-1:STATUS_W];
    results_seen++;
    if (due_results_q.size() == 0) begin
      bad_results++;
      if (bad_results <= 10)
        $display("result %0d: none due, got status %0d entries %0d",
                 results_seen, got_status, got_entries);
    end else begin
      want = due_results_q.pop_front();
      if (got_status !== want.status || got_entries !== want.entries) begin
        bad_results++;
        if (bad_results <= 10)
          $display("result %0d: expected status %0d entries %0d, got status %0d entries %0d",
                   results_seen, want.status, want.entries, got_status, got_entries);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i)
        check_result(m_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i)
        due_results_q.push_back(apply_request(kind_e'(s_axis_tuser_i),
                                              key_t'(s_axis_tdata_i[KEY_FIELD_W-1:0])));
    end
    mismatch_count_o <= bad_results;
    pending_o        <= due_results_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// tb_top: drives insert and delete requests into sorted_key_set_top with random
// gaps and output stalls, and gives the verdict. Depends on sks_pkg,
// sorted_key_set_top and sks_checker.
`timescale 1ns / 1ps

module tb_top;
  import sks_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_PHASES = 33;
  localparam int unsigned PHASE_LEN   = 50;
  localparam int unsigned POOL_SIZE   = 24;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  key_t        key_pool[POOL_SIZE];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sorted_key_set_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  sks_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .s_axis_tuser_i   (s_axis_tuser),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left    <= idle_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(kind_e kind, key_t key);
    int unsigned gap;
    gap = gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= IN_DATA_W'(key);
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic key_t pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return key_t'($urandom_range(0, 16'hFFFF));
  endfunction

  initial begin
    int unsigned insert_pct;
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = key_t'($urandom_range(0, 16'hFFFF));
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty set, extremes, duplicate, fill up, full, present-while-full
    send_request(KIND_DELETE, key_t'(16'h0005));
    send_request(KIND_INSERT, key_t'(16'hFFFF));
    send_request(KIND_INSERT, key_t'(16'h0000));
    send_request(KIND_INSERT, key_t'(16'h0000));
    for (int i = 14; i >= 1; i--)
      send_request(KIND_INSERT, key_t'(i * 4099 + 7));
    send_request(KIND_INSERT, key_t'(16'h1234));
    send_request(KIND_INSERT, key_t'(16'hFFFF));
    send_request(KIND_DELETE, key_t'(16'h0000));
    send_request(KIND_DELETE, key_t'(16'h0000));
    send_request(KIND_DELETE, key_t'(16'hFFFF));

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 50;
        default: insert_pct = 15;
      endcase
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < POOL_SIZE / 3; i++)
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = key_t'($urandom_range(0, 16'hFFFF));
      for (int i = 0; i < PHASE_LEN; i++)
        send_request(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DELETE,
                     pick_key());
    end
    s_axis_tvalid <= 1'b0;

    stalls_on = 1'b1;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
